>>> rtl/core/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// Types, codes and helpers for the B-spline curve sweep core.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int COORD_W    = 16;
    localparam int CURVE_W    = 20;
    localparam int KNOT_W     = 17;
    localparam int ORDER_W    = 4;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MUL_W      = 18;
    localparam int PROD_W     = 36;
    localparam int ACC_W      = 40;
    localparam int SUM_W      = ACC_W + 1;
    localparam int RND_W      = ACC_W - 11;
    localparam int DIV_CNT_W  = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd17;
    localparam logic [KNOT_W-1:0]    Q16_ONE   = 17'h10000;
    localparam int SAT_HI = 524287;
    localparam int SAT_LO = -524288;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SWEEP  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ARGS = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOT_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_U    = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } req_t;

    typedef struct packed {
        logic signed [CURVE_W-1:0] curve_x;
        logic signed [CURVE_W-1:0] curve_y;
        logic [1:0]                status;
        logic                      last;
    } rsp_t;

    // Q24.16 sum to Q16.4, nearest with ties up, saturated
    function automatic logic signed [CURVE_W-1:0] to_q4(input logic signed [ACC_W-1:0] acc);
        logic signed [SUM_W-1:0] sum;
        logic signed [RND_W-1:0] r;
        sum = SUM_W'(acc) + SUM_W'(2048);
        r   = RND_W'(sum >>> 12);
        if (r > RND_W'(SAT_HI))
            r = RND_W'(SAT_HI);
        else if (r < RND_W'(SAT_LO))
            r = RND_W'(SAT_LO);
        return CURVE_W'(r);
    endfunction

endpackage

>>> rtl/core/bspline_curve_sweep_core.sv
// ----------------------------------------------------------------------------
// bspline_curve_sweep_core
// Control point store and Cox-de Boor curve sweep on one shared multiplier
// and one 17-step restoring divider under a small sequencer.
// Sweep: builds the nk+1 knots first, then for each sample the basis
//   triangle and the sum over all points.
// Throughput: one request at a time; busy stays high for the whole sweep.
// One result per strobe cycle; the receiver cannot stall.
// Reset: state and config to defaults, point count cleared; rest is garbage.
// ----------------------------------------------------------------------------
module bspline_curve_sweep_core
    import bcs_pkg::*;
#(
    parameter int MAX_POINTS  = 16,
    parameter int MAX_ORDER   = 8,
    parameter int MAX_SAMPLES = 64
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  request,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output rsp_t                  result
);

    localparam int KD = MAX_POINTS + MAX_ORDER + 1;
    localparam int KW = $clog2(KD);
    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = $clog2(MAX_SAMPLES);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_KNOT  = 5'd1;
    localparam logic [4:0] S_DLD   = 5'd2;
    localparam logic [4:0] S_DRUN  = 5'd3;
    localparam logic [4:0] S_CHECK = 5'd4;
    localparam logic [4:0] S_B1    = 5'd5;
    localparam logic [4:0] S_T0    = 5'd6;
    localparam logic [4:0] S_T1    = 5'd7;
    localparam logic [4:0] S_T2    = 5'd8;
    localparam logic [4:0] S_T3    = 5'd9;
    localparam logic [4:0] S_MA    = 5'd10;
    localparam logic [4:0] S_MB    = 5'd11;
    localparam logic [4:0] S_WB    = 5'd12;
    localparam logic [4:0] S_AX    = 5'd13;
    localparam logic [4:0] S_AXA   = 5'd14;
    localparam logic [4:0] S_AY    = 5'd15;
    localparam logic [4:0] S_AYA   = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    localparam logic [1:0] RET_KNOT = 2'd0;
    localparam logic [1:0] RET_A    = 2'd1;
    localparam logic [1:0] RET_B    = 2'd2;

    logic signed [COORD_W-1:0] ctrl_x_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] ctrl_y_mem [MAX_POINTS];
    logic [KNOT_W-1:0]         knot_mem   [KD];
    logic [KNOT_W-1:0]         basis_mem  [KD];

    logic [4:0]               state_reg, state_next;
    logic [ORDER_W-1:0]       order_reg;
    logic                     mode_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [KW-1:0]            idx_reg, idx_next;
    logic [ORDER_W-1:0]       lvl_reg, lvl_next;
    logic [KW-1:0]            nk_reg, nk_next;
    logic [SW-1:0]            smp_reg, smp_next;
    logic [KNOT_W-1:0]        u_reg, u_next;
    logic [KNOT_W-1:0]        ubeg_reg, ubeg_next;
    logic [KNOT_W-1:0]        uend_reg, uend_next;
    logic [KNOT_W-1:0]        ti_reg, ti_next;
    logic [KNOT_W-1:0]        ti1_reg, ti1_next;
    logic [KNOT_W-1:0]        tl_reg, tl_next;
    logic [KNOT_W-1:0]        tr_reg, tr_next;
    logic [KNOT_W-1:0]        bi_reg, bi_next;
    logic [KNOT_W-1:0]        bi1_reg, bi1_next;
    logic [KNOT_W-1:0]        v_reg, v_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [KNOT_W-1:0]        den_reg, den_next;
    logic [KNOT_W-1:0]        rem_reg, rem_next;
    logic [KNOT_W-1:0]        lo_reg, lo_next;
    logic [KNOT_W-1:0]        q_reg, q_next;
    logic [DIV_CNT_W-1:0]     dcnt_reg, dcnt_next;
    logic [1:0]               ret_reg, ret_next;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0]  acc_y_reg, acc_y_next;
    logic                     done_reg, done_next;
    rsp_t                     result_reg, result_next;

    logic [KW-1:0]            knot_raddr, basis_raddr, basis_waddr, nk_calc, n_idx;
    logic [KNOT_W-1:0]        knot_rd, basis_rd, knot_wdata, basis_wdata;
    logic                     knot_we, basis_we, ctrl_we, bad_sweep, last_smp;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [KNOT_W:0]          trial;
    logic                     ge;

    assign knot_rd  = knot_mem[knot_raddr];
    assign basis_rd = basis_mem[basis_raddr];
    assign mul_p    = mul_a * mul_b;
    assign trial    = {rem_reg, lo_reg[KNOT_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign nk_calc  = KW'(cnt_reg) - KW'(1) + KW'(order_reg);
    assign n_idx    = KW'(cnt_reg) - KW'(1);
    assign last_smp = (smp_reg == SW'(MAX_SAMPLES - 1)) ||
                      ((18'(u_reg) + 18'(step_reg)) > 18'(uend_reg));
    assign bad_sweep = (cnt_reg == '0) || (order_reg == '0) ||
                       (32'(order_reg) > MAX_ORDER) || (CW'(order_reg) > cnt_reg) ||
                       (mode_reg && (nk_calc <= KW'(4)));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        lvl_next    = lvl_reg;
        nk_next     = nk_reg;
        smp_next    = smp_reg;
        u_next      = u_reg;
        ubeg_next   = ubeg_reg;
        uend_next   = uend_reg;
        ti_next     = ti_reg;
        ti1_next    = ti1_reg;
        tl_next     = tl_reg;
        tr_next     = tr_reg;
        bi_next     = bi_reg;
        bi1_next    = bi1_reg;
        v_next      = v_reg;
        prod_next   = prod_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        lo_next     = lo_reg;
        q_next      = q_reg;
        dcnt_next   = dcnt_reg;
        ret_next    = ret_reg;
        acc_x_next  = acc_x_reg;
        acc_y_next  = acc_y_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        knot_raddr  = idx_reg;
        basis_raddr = idx_reg;
        basis_waddr = idx_reg;
        knot_we     = 1'b0;
        knot_wdata  = q_reg;
        basis_we    = 1'b0;
        basis_wdata = v_reg;
        ctrl_we     = 1'b0;
        mul_a       = '0;
        mul_b       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (request.op)
                        OP_APPEND:
                        begin
                            if (32'(cnt_reg) >= MAX_POINTS)
                            begin
                                done_next   = 1'b1;
                                result_next = '{curve_x: '0, curve_y: '0,
                                                status: ST_FULL, last: 1'b1};
                            end
                            else
                            begin
                                ctrl_we  = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        OP_SWEEP:
                        begin
                            if (bad_sweep)
                            begin
                                done_next   = 1'b1;
                                result_next = '{curve_x: '0, curve_y: '0,
                                                status: ST_BAD_ARGS, last: 1'b1};
                            end
                            else
                            begin
                                nk_next    = nk_calc;
                                idx_next   = '0;
                                state_next = S_KNOT;
                            end
                        end
                        OP_CLEAR: cnt_next = '0;
                        default: ;
                    endcase
                end
            end
            S_KNOT:
            begin
                ret_next = RET_KNOT;
                if (!mode_reg)
                begin
                    prod_next  = PROD_W'({idx_reg, 16'h0}) + PROD_W'(nk_reg >> 1);
                    den_next   = KNOT_W'(nk_reg);
                    state_next = S_DLD;
                end
                else if (idx_reg >= KW'(3) && idx_reg <= nk_reg - KW'(2))
                begin
                    prod_next  = PROD_W'({idx_reg - KW'(2), 16'h0}) +
                                 PROD_W'((nk_reg - KW'(4)) >> 1);
                    den_next   = KNOT_W'(nk_reg - KW'(4));
                    state_next = S_DLD;
                end
                else
                begin
                    knot_we    = 1'b1;
                    knot_wdata = (idx_reg < KW'(3)) ? '0 : Q16_ONE;
                    idx_next   = idx_reg + KW'(1);
                    state_next = (idx_reg == nk_reg) ? S_CHECK : S_KNOT;
                end
            end
            S_DLD:
            begin
                rem_next   = {1'b0, prod_reg[32:17]};
                lo_next    = prod_reg[16:0];
                q_next     = '0;
                dcnt_next  = DIV_STEPS;
                state_next = S_DRUN;
            end
            S_DRUN:
            begin
                if (dcnt_reg != '0)
                begin
                    rem_next  = ge ? KNOT_W'(trial - {1'b0, den_reg}) : trial[KNOT_W-1:0];
                    lo_next   = {lo_reg[KNOT_W-2:0], 1'b0};
                    q_next    = {q_reg[KNOT_W-2:0], ge};
                    dcnt_next = dcnt_reg - DIV_CNT_W'(1);
                end
                else
                begin
                    case (ret_reg)
                        RET_KNOT:
                        begin
                            knot_we    = 1'b1;
                            idx_next   = idx_reg + KW'(1);
                            state_next = (idx_reg == nk_reg) ? S_CHECK : S_KNOT;
                        end
                        RET_A:
                        begin
                            v_next     = v_reg + q_reg;
                            state_next = S_MB;
                        end
                        default:
                        begin
                            v_next     = v_reg + q_reg;
                            state_next = S_WB;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (uend_reg < ubeg_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{curve_x: '0, curve_y: '0,
                                    status: ST_BAD_ARGS, last: 1'b1};
                    state_next  = S_IDLE;
                end
                else
                begin
                    u_next     = ubeg_reg;
                    smp_next   = '0;
                    idx_next   = '0;
                    state_next = S_B1;
                end
            end
            S_B1:
            begin
                acc_x_next  = '0;
                acc_y_next  = '0;
                ti_next     = knot_rd;
                basis_waddr = idx_reg - KW'(1);
                basis_wdata = (ti_reg <= u_reg && u_reg < knot_rd) ? Q16_ONE : '0;
                basis_we    = (idx_reg != '0);
                if (idx_reg == nk_reg)
                begin
                    idx_next   = '0;
                    lvl_next   = ORDER_W'(2);
                    state_next = (order_reg < ORDER_W'(2)) ? S_AX : S_T0;
                end
                else
                    idx_next = idx_reg + KW'(1);
            end
            S_T0:
            begin
                ti_next    = knot_rd;
                bi_next    = basis_rd;
                state_next = S_T1;
            end
            S_T1:
            begin
                knot_raddr  = idx_reg + KW'(1);
                basis_raddr = idx_reg + KW'(1);
                ti1_next    = knot_rd;
                bi1_next    = basis_rd;
                state_next  = S_T2;
            end
            S_T2:
            begin
                knot_raddr = idx_reg + KW'(lvl_reg) - KW'(1);
                tl_next    = knot_rd;
                state_next = S_T3;
            end
            S_T3:
            begin
                knot_raddr = idx_reg + KW'(lvl_reg);
                tr_next    = knot_rd;
                v_next     = '0;
                state_next = S_MA;
            end
            S_MA:
            begin
                mul_a = {1'b0, bi_reg};
                mul_b = {1'b0, KNOT_W'(u_reg - ti_reg)};
                if (tl_reg != ti_reg && bi_reg != '0)
                begin
                    prod_next  = mul_p;
                    den_next   = tl_reg - ti_reg;
                    ret_next   = RET_A;
                    state_next = S_DLD;
                end
                else
                    state_next = S_MB;
            end
            S_MB:
            begin
                mul_a = {1'b0, bi1_reg};
                mul_b = {1'b0, KNOT_W'(tr_reg - u_reg)};
                if (tr_reg != ti1_reg && bi1_reg != '0)
                begin
                    prod_next  = mul_p;
                    den_next   = tr_reg - ti1_reg;
                    ret_next   = RET_B;
                    state_next = S_DLD;
                end
                else
                    state_next = S_WB;
            end
            S_WB:
            begin
                basis_we = 1'b1;
                if (idx_reg == nk_reg - KW'(lvl_reg))
                begin
                    idx_next = '0;
                    if (lvl_reg == order_reg)
                        state_next = S_AX;
                    else
                    begin
                        lvl_next   = lvl_reg + ORDER_W'(1);
                        state_next = S_T0;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + KW'(1);
                    state_next = S_T0;
                end
            end
            S_AX:
            begin
                mul_a      = MUL_W'(ctrl_x_mem[idx_reg[PW-1:0]]);
                mul_b      = {1'b0, basis_rd};
                prod_next  = mul_p;
                state_next = S_AXA;
            end
            S_AXA:
            begin
                acc_x_next = acc_x_reg + ACC_W'(prod_reg);
                state_next = S_AY;
            end
            S_AY:
            begin
                mul_a      = MUL_W'(ctrl_y_mem[idx_reg[PW-1:0]]);
                mul_b      = {1'b0, basis_rd};
                prod_next  = mul_p;
                state_next = S_AYA;
            end
            S_AYA:
            begin
                acc_y_next = acc_y_reg + ACC_W'(prod_reg);
                if (idx_reg == n_idx)
                    state_next = S_OUT;
                else
                begin
                    idx_next   = idx_reg + KW'(1);
                    state_next = S_AX;
                end
            end
            S_OUT:
            begin
                done_next   = 1'b1;
                result_next = '{curve_x: to_q4(acc_x_reg), curve_y: to_q4(acc_y_reg),
                                status: ST_OK, last: last_smp};
                idx_next    = '0;
                if (last_smp)
                    state_next = S_IDLE;
                else
                begin
                    u_next     = u_reg + KNOT_W'(step_reg);
                    smp_next   = smp_reg + SW'(1);
                    state_next = S_B1;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (knot_we)
        begin
            if (idx_reg == KW'(order_reg) - KW'(1))
                ubeg_next = knot_wdata;
            if (idx_reg == KW'(cnt_reg))
                uend_next = knot_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            order_reg <= ORDER_W'(3);
            mode_reg  <= 1'b0;
            step_reg  <= STEP_W'(1311);
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            dcnt_reg  <= dcnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ORDER:     order_reg <= cfg_data[ORDER_W-1:0];
                    CFG_KNOT_MODE: mode_reg  <= cfg_data[0];
                    CFG_STEP_U:    step_reg  <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        lvl_reg    <= lvl_next;
        nk_reg     <= nk_next;
        smp_reg    <= smp_next;
        u_reg      <= u_next;
        ubeg_reg   <= ubeg_next;
        uend_reg   <= uend_next;
        ti_reg     <= ti_next;
        ti1_reg    <= ti1_next;
        tl_reg     <= tl_next;
        tr_reg     <= tr_next;
        bi_reg     <= bi_next;
        bi1_reg    <= bi1_next;
        v_reg      <= v_next;
        prod_reg   <= prod_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        q_reg      <= q_next;
        ret_reg    <= ret_next;
        acc_x_reg  <= acc_x_next;
        acc_y_reg  <= acc_y_next;
        result_reg <= result_next;
        if (ctrl_we)
        begin
            ctrl_x_mem[cnt_reg[PW-1:0]] <= request.point_x;
            ctrl_y_mem[cnt_reg[PW-1:0]] <= request.point_y;
        end
        if (knot_we)
            knot_mem[idx_reg] <= knot_wdata;
        if (basis_we)
            basis_mem[basis_waddr] <= basis_wdata;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.last && result.curve_x == '0)
        else $error("error request not a single final result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MAX_POINTS)
        else $error("point count beyond store depth");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRUN |-> den_reg != '0)
        else $error("divider started with zero divisor");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.last |-> !busy)
        else $error("busy after final result");

endmodule
